/* rtl/assembly_token_scanner_defines.svh */
// Assertion macros shared by the token scanner RTL.
`ifndef ASSEMBLY_TOKEN_SCANNER_DEFINES_SVH
`define ASSEMBLY_TOKEN_SCANNER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ATS_ASSERT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ATS_ASSERT_NX(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/ats_pkg.sv */
// Types, codes and character classes of the assembly token scanner.
`timescale 1ns / 1ps
`default_nettype none
package ats_pkg;

  // Input request: one source character or an end-of-source marker.
  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
  } ats_in_t;

  // Output request: one token.
  typedef struct packed {
    logic [2:0]  token_type;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        last;
  } ats_out_t;

  // Up to two tokens produced by one input request.
  typedef struct packed {
    ats_out_t   r1;
    ats_out_t   r0;
    logic [1:0] cnt;
  } ats_pair_t;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_REG  = 2'd1;
  localparam logic [1:0] MODE_INT  = 2'd2;
  localparam logic [1:0] MODE_OPC  = 2'd3;

  localparam logic [2:0] TOK_EOF   = 3'd0;
  localparam logic [2:0] TOK_NL    = 3'd1;
  localparam logic [2:0] TOK_COMMA = 3'd2;
  localparam logic [2:0] TOK_COLON = 3'd3;
  localparam logic [2:0] TOK_REG   = 3'd4;
  localparam logic [2:0] TOK_INT   = 3'd5;
  localparam logic [2:0] TOK_OPC   = 3'd6;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Configuration register map.
  localparam int unsigned APB_AW         = 3;
  localparam logic        IDX_FIRST_LINE = 1'b0;
  localparam logic [15:0] FIRST_LINE_RST = 16'd1;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return is_digit(c) || is_alpha(c);
  endfunction

  // True when character c continues a pending token of the given mode.
  function automatic logic continues_tok(logic [1:0] mode, logic [7:0] c);
    logic r;
    case (mode)
      MODE_REG: r = is_alnum(c);
      MODE_INT: r = is_digit(c);
      MODE_OPC: r = is_alnum(c) || (c == CH_DOT) || (c == CH_USCORE);
      default:  r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] mode_tok(logic [1:0] mode);
    logic [2:0] t;
    case (mode)
      MODE_REG: t = TOK_REG;
      MODE_INT: t = TOK_INT;
      MODE_OPC: t = TOK_OPC;
      default:  t = TOK_EOF;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

/* rtl/ats_apb.sv */
// APB register block holding the first-line configuration register.
`timescale 1ns / 1ps
`default_nettype none
module ats_apb (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ats_pkg::APB_AW-1:0]    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  output logic      [15:0]                   first_line_o
);
  import ats_pkg::*;

  logic [15:0] first_line_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == IDX_FIRST_LINE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_line_q <= FIRST_LINE_RST;
    end else if (wr_en) begin
      first_line_q <= pwdata[15:0];
    end
  end

  assign prdata       = (paddr[2] == IDX_FIRST_LINE) ? {16'b0, first_line_q} : 32'b0;
  assign first_line_o = first_line_q;

endmodule
`default_nettype wire

/* rtl/ats_step.sv */
// Per-character scanner step: next scanner state and the tokens it emits.
`timescale 1ns / 1ps
`default_nettype none
module ats_step #(
  parameter int unsigned POS_BITS = 16
) (
  input  wire ats_pkg::ats_in_t     item_i,
  input  wire logic [1:0]           mode_i,
  input  wire logic [POS_BITS-1:0]  pstart_i,
  input  wire logic [POS_BITS-1:0]  pos_i,
  input  wire logic [15:0]          line_i,
  input  wire logic [15:0]          first_line_i,
  output logic      [1:0]           mode_o,
  output logic      [POS_BITS-1:0]  pstart_o,
  output logic      [POS_BITS-1:0]  pos_o,
  output logic      [15:0]          line_o,
  output ats_pkg::ats_pair_t        pair_o
);
  import ats_pkg::*;

  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  // Low 16 bits of a position, zero-extended when positions are narrower.
  function automatic logic [15:0] fit16(logic [POS_BITS-1:0] v);
    logic [POS_BITS+15:0] e;
    e = {16'b0, v};
    return e[15:0];
  endfunction

  logic [POS_BITS-1:0] pos_inc;
  logic [15:0]         line_inc;
  logic                flush_v;
  ats_out_t            flush_tok;
  ats_out_t            eof_tok;
  ats_out_t            one_tok;
  logic                have_tok;
  logic [7:0]          c;

  assign c        = item_i.ch;
  assign pos_inc  = (pos_i == POS_MAX) ? pos_i : pos_i + 1'b1;
  assign line_inc = (line_i == 16'hFFFF) ? line_i : line_i + 16'd1;
  assign flush_v  = (mode_i != MODE_NONE);

  always_comb begin
    flush_tok.token_type   = mode_tok(mode_i);
    flush_tok.token_start  = fit16(pstart_i);
    flush_tok.token_length = fit16(pos_i - pstart_i);
    flush_tok.line_number  = line_i;
    flush_tok.last         = 1'b0;

    eof_tok.token_type   = TOK_EOF;
    eof_tok.token_start  = fit16(pos_i);
    eof_tok.token_length = 16'd0;
    eof_tok.line_number  = line_i;
    eof_tok.last         = 1'b1;

    one_tok.token_type   = TOK_OPC;
    one_tok.token_start  = fit16(pos_i);
    one_tok.token_length = 16'd1;
    one_tok.line_number  = line_i;
    one_tok.last         = 1'b1;

    have_tok = 1'b0;
    mode_o   = mode_i;
    pstart_o = pstart_i;
    pos_o    = pos_i;
    line_o   = line_i;
    pair_o   = '0;

    if (item_i.kind == KIND_END) begin
      if (flush_v) begin
        pair_o.r0  = flush_tok;
        pair_o.r1  = eof_tok;
        pair_o.cnt = 2'd2;
      end else begin
        pair_o.r0  = eof_tok;
        pair_o.cnt = 2'd1;
      end
      mode_o   = MODE_NONE;
      pstart_o = '0;
      pos_o    = '0;
      line_o   = first_line_i;
    end else if (flush_v && continues_tok(mode_i, c)) begin
      pos_o = pos_inc;
    end else begin
      mode_o = MODE_NONE;
      pos_o  = pos_inc;
      if ((c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR)) begin
        have_tok = 1'b0;
      end else if (c == CH_LF) begin
        have_tok               = 1'b1;
        line_o                 = line_inc;
        one_tok.token_type     = TOK_NL;
        one_tok.line_number    = line_inc;
      end else if (c == CH_COMMA) begin
        have_tok           = 1'b1;
        one_tok.token_type = TOK_COMMA;
      end else if (c == CH_COLON) begin
        have_tok           = 1'b1;
        one_tok.token_type = TOK_COLON;
      end else if (c == CH_PCT) begin
        mode_o   = MODE_REG;
        pstart_o = pos_i;
      end else if (is_digit(c) || (c == CH_MINUS)) begin
        mode_o   = MODE_INT;
        pstart_o = pos_i;
      end else if (is_alpha(c) || (c == CH_DOT) || (c == CH_USCORE)) begin
        mode_o   = MODE_OPC;
        pstart_o = pos_i;
      end else begin
        have_tok = 1'b1;
      end

      if (flush_v && have_tok) begin
        pair_o.r0  = flush_tok;
        pair_o.r1  = one_tok;
        pair_o.cnt = 2'd2;
      end else if (flush_v) begin
        pair_o.r0      = flush_tok;
        pair_o.r0.last = 1'b1;
        pair_o.cnt     = 2'd1;
      end else if (have_tok) begin
        pair_o.r0  = one_tok;
        pair_o.cnt = 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/ats_out.sv */
// Result register: holds up to two tokens and presents them one per request.
`timescale 1ns / 1ps
`default_nettype none
`include "assembly_token_scanner_defines.svh"
module ats_out (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire ats_pkg::ats_pair_t pair_i,
  output logic                    free_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output ats_pkg::ats_out_t       out_req_o
);
  import ats_pkg::*;

  ats_out_t   r0_q;
  ats_out_t   r1_q;
  logic [1:0] rem_q;
  logic       idx_q;
  logic       pop;

  assign out_valid_o = (rem_q != 2'd0);
  assign out_req_o   = idx_q ? r1_q : r0_q;
  assign pop         = out_valid_o && !out_stall_i;
  // The register can take a new pair when empty or when its final token leaves now.
  assign free_o      = (rem_q == 2'd0) || (pop && (rem_q == 2'd1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
      idx_q <= 1'b0;
    end else if (load_i) begin
      rem_q <= pair_i.cnt;
      idx_q <= 1'b0;
    end else if (pop) begin
      rem_q <= rem_q - 2'd1;
      idx_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      r0_q <= pair_i.r0;
      r1_q <= pair_i.r1;
    end
  end

  `ATS_ASSERT(a_load_when_free, load_i, free_o, "pair loaded over undelivered tokens")
  `ATS_ASSERT(a_last_on_final, out_valid_o && (rem_q == 2'd1), out_req_o.last, "final token lacks last")
  `ATS_ASSERT(a_no_last_early, rem_q == 2'd2, !out_req_o.last, "last flag on first of two tokens")
  `ATS_ASSERT_NX(a_second_follows, pop && (rem_q == 2'd2), (rem_q == 2'd1) && idx_q, "second token not presented")

endmodule
`default_nettype wire

/* rtl/assembly_token_scanner.sv */
// Top level of the streaming assembly token scanner.
//
//   Channel   Direction  Handshake                Payload
//   in        sink       in_valid_i / in_stall_o  in_req_i  (kind, ch)
//   out       source     out_valid_o / out_stall_i out_req_o (type, start, length, line, last)
//   cfg       APB slave  psel, penable, pwrite    paddr, pwdata, prdata
//
// A request is taken into the input register, then scanned by the combinational
// step logic, which updates the scanner state and loads the result register, whose
// token is the output. One character per cycle is sustained while the output does
// not stall; a request that yields two tokens holds the result register until both
// have left, so the input rate is then set by the output port, one token per cycle.
// Reset clears the pending mode, position and start, and loads the line count
// with the reset value of the first-line register. A stalled output holds its
// token; the input register still takes one more request meanwhile, and
// characters that extend a pending token pass through without waiting at all.
`timescale 1ns / 1ps
`default_nettype none
`include "assembly_token_scanner_defines.svh"
module assembly_token_scanner #(
  parameter int unsigned POS_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire ats_pkg::ats_in_t            in_req_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output ats_pkg::ats_out_t                out_req_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [ats_pkg::APB_AW-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);
  import ats_pkg::*;

  // Input register.
  logic                in_valid_q;
  ats_in_t             in_item_q;

  // Scanner state.
  logic [1:0]          mode_q, mode_d;
  logic [POS_BITS-1:0] pstart_q, pstart_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [15:0]         line_q, line_d;

  logic [15:0]         first_line;
  ats_pair_t           pair;
  logic                out_free;
  logic                consume;
  logic                accept;

  ats_apb u_apb (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .first_line_o (first_line)
  );

  ats_step #(
    .POS_BITS (POS_BITS)
  ) u_step (
    .item_i       (in_item_q),
    .mode_i       (mode_q),
    .pstart_i     (pstart_q),
    .pos_i        (pos_q),
    .line_i       (line_q),
    .first_line_i (first_line),
    .mode_o       (mode_d),
    .pstart_o     (pstart_d),
    .pos_o        (pos_d),
    .line_o       (line_d),
    .pair_o       (pair)
  );

  // A held request is scanned when its tokens fit, or at once if it makes none.
  assign consume    = in_valid_q && ((pair.cnt == 2'd0) || out_free);
  assign in_stall_o = in_valid_q && !consume;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (consume) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= in_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_NONE;
      pstart_q <= '0;
      pos_q    <= '0;
      line_q   <= FIRST_LINE_RST;
    end else if (consume) begin
      mode_q   <= mode_d;
      pstart_q <= pstart_d;
      pos_q    <= pos_d;
      line_q   <= line_d;
    end
  end

  ats_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (consume && (pair.cnt != 2'd0)),
    .pair_i      (pair),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  `ATS_ASSERT(a_stall_needs_held, in_stall_o, in_valid_q && (pair.cnt != 2'd0), "input stalled without pending tokens")
  `ATS_ASSERT_NX(a_end_rewinds, consume && (in_item_q.kind == KIND_END), (pos_q == '0) && (mode_q == MODE_NONE), "end of source did not rewind")

endmodule
`default_nettype wire
